// ----- rtl/core/gpsr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the game pad serial reader: widths, phase encoding, button mapping
// tables and the result record; shared by the sequencer, decoder and output register.
// No dependencies.
package gpsr_pkg;

  // Width of the tick counter; longer durations are cut to 2^CNT_W ticks.
  localparam int CNT_W = 16;
  // Compare width: holds the counter plus one carry bit and any 16 bit limit.
  localparam int CMP_W = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << CNT_W) - 64'd1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_STARTUP_WAIT = 2'd0;
  localparam logic [1:0] CFG_LATCH_TICKS  = 2'd1;
  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd2;

  // Register reset values.
  localparam logic [15:0] STARTUP_WAIT_RST = 16'd10000;
  localparam logic [7:0]  LATCH_TICKS_RST  = 8'd12;
  localparam logic [7:0]  HALF_PERIOD_RST  = 8'd6;

  // Bits per frame.
  localparam logic [4:0] DISC_BITS  = 5'd8;
  localparam logic [4:0] FRAME_BITS = 5'd16;

  // Discovery byte patterns (first bit on the wire is the MSB, 1 = pressed).
  localparam logic [7:0] DISC_ONLY_B      = 8'b1000_0000;
  localparam logic [7:0] DISC_ONLY_Y      = 8'b0100_0000;
  localparam logic [7:0] DISC_ONLY_SELECT = 8'b0010_0000;
  localparam logic [7:0] DISC_ONLY_START  = 8'b0001_0000;

  typedef logic [2:0] gpsr_map_t;

  localparam gpsr_map_t MAP_DEFAULT = 3'd0;
  localparam gpsr_map_t MAP_B       = 3'd1;
  localparam gpsr_map_t MAP_Y       = 3'd2;
  localparam gpsr_map_t MAP_START   = 3'd3;
  localparam gpsr_map_t MAP_SELECT  = 3'd4;
  localparam gpsr_map_t MAP_LAST    = 3'd4;

  // Wire position of the button driving action 1..6, for each mapping.
  // Wire order: B Y Select Start Up Down Left Right A X L R.
  localparam logic [3:0] ACTION_SRC [0:4][0:5] = '{
    '{4'd8, 4'd0, 4'd9,  4'd1, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd8,  4'd9, 4'd10, 4'd11},
    '{4'd1, 4'd0, 4'd8,  4'd9, 4'd10, 4'd11},
    '{4'd1, 4'd9, 4'd10, 4'd0, 4'd8,  4'd11},
    '{4'd0, 4'd8, 4'd10, 4'd1, 4'd9,  4'd11}
  };

  // Sequencer phases, one-hot.
  typedef enum logic [7:0] {
    PH_WAIT        = 8'b0000_0001,
    PH_DISC_LATCH  = 8'b0000_0010,
    PH_DISC_LOW    = 8'b0000_0100,
    PH_DISC_HIGH   = 8'b0000_1000,
    PH_IDLE        = 8'b0001_0000,
    PH_FRAME_LATCH = 8'b0010_0000,
    PH_FRAME_LOW   = 8'b0100_0000,
    PH_FRAME_HIGH  = 8'b1000_0000
  } gpsr_phase_t;

  // One result per tick.
  typedef struct packed {
    logic        latch_pin;
    logic        clock_pin;
    logic [11:0] button_bits;
    logic        frame_done;
    gpsr_map_t   active_mapping;
    logic        busy_res;
  } gpsr_result_t;

endpackage

// ----- rtl/core/gpsr_decode.sv -----
`timescale 1ns / 1ps
// Button decoder: maps a captured frame onto the twelve button outputs and
// classifies the discovery byte. Depends on gpsr_pkg.
module gpsr_decode
  import gpsr_pkg::*;
(
  input  logic [15:0] shift_bits,
  input  gpsr_map_t   pad_mapping,
  output logic [11:0] buttons,
  output gpsr_map_t   disc_mapping
);

  gpsr_map_t map_sel;

  // Frame decode: directions and start/coin are fixed, actions follow the table.
  always_comb begin
    map_sel = (pad_mapping <= MAP_LAST) ? pad_mapping : MAP_DEFAULT;
    buttons[0]  = shift_bits[11];
    buttons[1]  = shift_bits[10];
    buttons[2]  = shift_bits[9];
    buttons[3]  = shift_bits[8];
    for (int j = 0; j < 6; j++) begin
      buttons[4 + j] = shift_bits[4'(4'd15 - ACTION_SRC[map_sel][j])];
    end
    buttons[10] = shift_bits[12];
    buttons[11] = shift_bits[13];
  end

  // Discovery: a lone press of one of four buttons picks its mapping.
  always_comb begin
    case (shift_bits[7:0])
      DISC_ONLY_SELECT: disc_mapping = MAP_SELECT;
      DISC_ONLY_START:  disc_mapping = MAP_START;
      DISC_ONLY_B:      disc_mapping = MAP_B;
      DISC_ONLY_Y:      disc_mapping = MAP_Y;
      default:          disc_mapping = MAP_DEFAULT;
    endcase
  end

endmodule

// ----- rtl/core/gpsr_seq.sv -----
`timescale 1ns / 1ps
// Tick sequencer: configuration registers, phase machine, tick timer and shift
// register; produces one result per accepted tick. Depends on gpsr_pkg, gpsr_decode.
module gpsr_seq
  import gpsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         data_pin,
  input  logic         scan_request,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output gpsr_result_t res
);

  logic [15:0]     startup_wait_ticks;
  logic [7:0]      latch_ticks;
  logic [7:0]      half_period_ticks;

  gpsr_phase_t     phase;
  logic [CNT_W-1:0] tick_count;
  logic [4:0]      bit_index;
  logic [15:0]     shift_bits;
  gpsr_map_t       pad_mapping;
  logic [11:0]     held_buttons;

  gpsr_phase_t     phase_next;
  logic [CNT_W-1:0] tick_count_next;
  logic [4:0]      bit_index_next;
  logic [15:0]     shift_bits_next;
  gpsr_map_t       pad_mapping_next;
  logic [11:0]     held_buttons_next;

  gpsr_phase_t     ph;
  logic [CNT_W-1:0] tick_eff;
  logic [15:0]     limit;
  logic [15:0]     limit_eff;
  logic [CMP_W-1:0] cnt_inc;
  logic            last;
  logic [CNT_W-1:0] cnt_adv;
  logic            disc;
  logic [4:0]      total;
  logic            done;
  logic            latch_lvl;
  logic            clock_lvl;
  logic            busy;
  logic [11:0]     dec_buttons;
  gpsr_map_t       dec_mapping;

  gpsr_decode u_decode (
    .shift_bits   (shift_bits),
    .pad_mapping  (pad_mapping),
    .buttons      (dec_buttons),
    .disc_mapping (dec_mapping)
  );

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_wait_ticks <= STARTUP_WAIT_RST;
      latch_ticks        <= LATCH_TICKS_RST;
      half_period_ticks  <= HALF_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STARTUP_WAIT: startup_wait_ticks <= cfg_data;
        CFG_LATCH_TICKS:  latch_ticks        <= cfg_data[7:0];
        CFG_HALF_PERIOD:  half_period_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A request on an idle tick makes that tick the first latch tick.
  always_comb begin
    ph       = phase;
    tick_eff = tick_count;
    if (phase == PH_IDLE && scan_request) begin
      ph       = PH_FRAME_LATCH;
      tick_eff = '0;
    end
  end

  // Tick timer: the duration of the current phase, a zero setting counting as one.
  always_comb begin
    case (ph)
      PH_WAIT:                       limit = startup_wait_ticks;
      PH_DISC_LATCH, PH_FRAME_LATCH: limit = {8'd0, latch_ticks};
      default:                       limit = {8'd0, half_period_ticks};
    endcase
    limit_eff = (limit == 16'd0) ? 16'd1 : limit;
    cnt_inc   = CMP_W'(tick_eff) + CMP_W'(1);
    last      = (cnt_inc >= CMP_W'(limit_eff)) || (cnt_inc > CNT_MAX);
    cnt_adv   = last ? '0 : cnt_inc[CNT_W-1:0];
    disc      = (ph == PH_DISC_LATCH) || (ph == PH_DISC_LOW) || (ph == PH_DISC_HIGH);
    total     = disc ? DISC_BITS : FRAME_BITS;
  end

  // Phase machine and pin levels for this tick.
  always_comb begin
    phase_next        = ph;
    tick_count_next   = tick_eff;
    bit_index_next    = bit_index;
    shift_bits_next   = shift_bits;
    pad_mapping_next  = pad_mapping;
    held_buttons_next = held_buttons;
    latch_lvl         = 1'b0;
    clock_lvl         = 1'b1;
    busy              = 1'b1;
    done              = 1'b0;
    case (ph)
      PH_WAIT: begin
        latch_lvl       = 1'b1;
        tick_count_next = cnt_adv;
        if (last) begin
          phase_next = PH_DISC_LATCH;
        end
      end
      PH_IDLE: begin
        busy = 1'b0;
      end
      PH_DISC_LATCH, PH_FRAME_LATCH: begin
        latch_lvl       = 1'b1;
        tick_count_next = cnt_adv;
        if (last) begin
          phase_next     = disc ? PH_DISC_LOW : PH_FRAME_LOW;
          bit_index_next = '0;
        end
      end
      PH_DISC_LOW, PH_FRAME_LOW: begin
        clock_lvl       = 1'b0;
        tick_count_next = cnt_adv;
        if (last) begin
          shift_bits_next = {shift_bits[14:0], ~data_pin};
          bit_index_next  = bit_index + 5'd1;
          phase_next      = disc ? PH_DISC_HIGH : PH_FRAME_HIGH;
        end
      end
      PH_DISC_HIGH, PH_FRAME_HIGH: begin
        tick_count_next = cnt_adv;
        if (last) begin
          if (bit_index >= total) begin
            if (disc) begin
              pad_mapping_next = dec_mapping;
            end else begin
              held_buttons_next = dec_buttons;
              done              = 1'b1;
            end
            phase_next = PH_IDLE;
          end else begin
            phase_next = disc ? PH_DISC_LOW : PH_FRAME_LOW;
          end
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_bits   <= '0;
      pad_mapping  <= MAP_DEFAULT;
      held_buttons <= '0;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_bits   <= shift_bits_next;
      pad_mapping  <= pad_mapping_next;
      held_buttons <= held_buttons_next;
    end
  end

  // Result of this tick, taken by the output register on a transfer.
  always_comb begin
    res.latch_pin      = latch_lvl;
    res.clock_pin      = clock_lvl;
    res.button_bits    = held_buttons_next;
    res.frame_done     = done;
    res.active_mapping = pad_mapping_next;
    res.busy_res       = busy;
  end

  // A frame can only complete from the high half of a data frame's last bit.
  a_done_from_high: assert property (@(posedge clk) disable iff (rst)
    res.frame_done |-> (phase == PH_FRAME_HIGH && bit_index == FRAME_BITS))
    else $error("frame_done outside the end of a data frame");

  // A completed frame always leaves the sequencer idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.frame_done) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after a completed frame");

  // The bit counter never runs past a full frame.
  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    bit_index <= FRAME_BITS)
    else $error("bit index beyond frame length");

  // Latch and a low clock are never driven together.
  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(res.latch_pin && !res.clock_pin))
    else $error("latch high while clock is low");

endmodule

// ----- rtl/core/gpsr_outreg.sv -----
`timescale 1ns / 1ps
// Output register: holds one result until it is taken and frees the input side
// in the same cycle it drains. Depends on gpsr_pkg.
module gpsr_outreg
  import gpsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  gpsr_result_t res_in,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output gpsr_result_t res_out
);

  // Room for a new result when empty or when the held one leaves this cycle.
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/core/game_pad_serial_reader_top.sv -----
`timescale 1ns / 1ps
// Top level of the game pad serial reader: sequencer plus output register.
// Depends on gpsr_pkg, gpsr_seq, gpsr_outreg.
//
// Each input transfer is one time tick and yields exactly one result transfer
// carrying the latch and clock pin levels, the held buttons, the frame-done flag,
// the active mapping and the busy flag. The block sustains one tick per cycle;
// in_ready falls only while a
// result sits in the output register and out_ready is low. After reset the latch
// stays high for startup_wait_ticks ticks, then an 8 bit discovery frame picks the
// button mapping; afterwards each scan_request seen while idle starts a 16 bit
// frame. Configuration writes are accepted every cycle and should be issued only
// while the block is idle.
module game_pad_serial_reader_top
  import gpsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Tick input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        data_pin,
  input  logic        scan_request,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        latch_pin,
  output logic        clock_pin,
  output logic [11:0] button_bits,
  output logic        frame_done,
  output logic [2:0]  active_mapping,
  output logic        busy_res,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic         step;
  gpsr_result_t res_next;
  gpsr_result_t res_held;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  gpsr_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_pin     (data_pin),
    .scan_request (scan_request),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res          (res_next)
  );

  gpsr_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_held)
  );

  // Result fields onto their ports.
  assign latch_pin      = res_held.latch_pin;
  assign clock_pin      = res_held.clock_pin;
  assign button_bits    = res_held.button_bits;
  assign frame_done     = res_held.frame_done;
  assign active_mapping = res_held.active_mapping;
  assign busy_res       = res_held.busy_res;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the game pad serial reader, built on gpsr_pkg and
// game_pad_serial_reader_top: ticks go in, pin levels come out and are predicted.
module testbench
  import gpsr_pkg::*;
();

  // Register values after reset.
  localparam logic [15:0] RST_STARTUP = 16'd10000;
  localparam logic [7:0]  RST_LATCH   = 8'd12;
  localparam logic [7:0]  RST_HALF    = 8'd6;
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  // Discovery byte patterns, first wire bit as MSB, 1 = pressed.
  localparam logic [7:0]  PAT_ONLY_B      = 8'h80;
  localparam logic [7:0]  PAT_ONLY_Y      = 8'h40;
  localparam logic [7:0]  PAT_ONLY_SELECT = 8'h20;
  localparam logic [7:0]  PAT_ONLY_START  = 8'h10;
  localparam logic [4:0]  DISC_LEN  = 5'd8;
  localparam logic [4:0]  FRAME_LEN = 5'd16;
  localparam int LONG_HOLD  = 300;
  localparam int QUIET_MAX  = 2000;
  localparam int RAND_TICKS = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        data_pin = 1'b0;
  logic        scan_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        latch_pin;
  logic        clock_pin;
  logic [11:0] button_bits;
  logic        frame_done;
  logic [2:0]  active_mapping;
  logic        busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_UNUSED;
  logic [15:0] cfg_data = 16'h0000;

  // Tracks the pad reader tick by tick and holds the pin levels still to come out.
  class pad_scoreboard;
    logic [15:0]  startup_len;
    logic [7:0]   latch_len;
    logic [7:0]   half_len;
    gpsr_phase_t  phase;
    logic [15:0]  tick_cnt;
    logic [4:0]   bit_cnt;
    logic [15:0]  shift_reg;
    gpsr_map_t    mapping;
    logic [11:0]  buttons;
    gpsr_result_t pending_results[$];
    int           errors;

    function new();
      startup_len = RST_STARTUP;
      latch_len   = RST_LATCH;
      half_len    = RST_HALF;
      phase       = PH_WAIT;
      tick_cnt    = 16'd0;
      bit_cnt     = 5'd0;
      shift_reg   = 16'd0;
      mapping     = MAP_DEFAULT;
      buttons     = 12'd0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_STARTUP_WAIT: startup_len = val;
        CFG_LATCH_TICKS:  latch_len = val[7:0];
        CFG_HALF_PERIOD:  half_len = val[7:0];
        default: ;
      endcase
    endfunction

    // Counts one tick of a duration; a zero duration lasts one tick.
    function bit timer_done(logic [15:0] limit);
      logic [16:0] nxt;
      logic [16:0] lim;
      nxt = {1'b0, tick_cnt} + 17'd1;
      lim = (limit == 16'd0) ? 17'd1 : {1'b0, limit};
      if (nxt >= lim || nxt > 17'h0FFFF) begin
        tick_cnt = 16'd0;
        return 1'b1;
      end
      tick_cnt = nxt[15:0];
      return 1'b0;
    endfunction

    // True when the next tick is the one on which the data line is sampled.
    function bit samples_next();
      logic [16:0] lim;
      lim = (half_len == 8'd0) ? 17'd1 : {9'd0, half_len};
      return (phase == PH_DISC_LOW || phase == PH_FRAME_LOW) &&
             ({1'b0, tick_cnt} + 17'd1 >= lim);
    endfunction

    function gpsr_map_t pick_mapping(logic [7:0] pressed);
      case (pressed)
        PAT_ONLY_SELECT: return MAP_SELECT;
        PAT_ONLY_START:  return MAP_START;
        PAT_ONLY_B:      return MAP_B;
        PAT_ONLY_Y:      return MAP_Y;
        default:         return MAP_DEFAULT;
      endcase
    endfunction

    // Wire positions feeding action 1..6, one nibble each, action 1 on top.
    function logic [23:0] action_wires(gpsr_map_t m);
      case (m)
        MAP_B:      return 24'h0189AB;
        MAP_Y:      return 24'h1089AB;
        MAP_START:  return 24'h19A08B;
        MAP_SELECT: return 24'h08A19B;
        default:    return 24'h8091AB;
      endcase
    endfunction

    // The first wire bit of the frame sits in bit 15 of the shift register.
    function logic [11:0] map_buttons();
      logic [11:0] b;
      logic [23:0] src;
      logic [3:0]  w;
      src = action_wires(mapping);
      b[3:0] = {shift_reg[8], shift_reg[9], shift_reg[10], shift_reg[11]};
      for (int j = 0; j < 6; j++) begin
        w = src[23 - 4 * j -: 4];
        b[4 + j] = shift_reg[4'd15 - w];
      end
      b[10] = shift_reg[12];
      b[11] = shift_reg[13];
      return b;
    endfunction

    // Advances the reader by one accepted tick and queues the pin levels it gives.
    function void note_tick(logic d, logic req);
      gpsr_result_t r;
      bit           disc;
      logic [4:0]   total;
      r.latch_pin  = 1'b0;
      r.clock_pin  = 1'b1;
      r.frame_done = 1'b0;
      r.busy_res   = 1'b1;
      if (phase == PH_IDLE && req) begin
        phase = PH_FRAME_LATCH;
        tick_cnt = 16'd0;
      end
      disc  = (phase == PH_DISC_LATCH || phase == PH_DISC_LOW || phase == PH_DISC_HIGH);
      total = disc ? DISC_LEN : FRAME_LEN;
      case (phase)
        PH_WAIT: begin
          r.latch_pin = 1'b1;
          if (timer_done(startup_len)) phase = PH_DISC_LATCH;
        end
        PH_IDLE: r.busy_res = 1'b0;
        PH_DISC_LATCH, PH_FRAME_LATCH: begin
          r.latch_pin = 1'b1;
          if (timer_done({8'd0, latch_len})) begin
            bit_cnt = 5'd0;
            if (disc) phase = PH_DISC_LOW;
            else phase = PH_FRAME_LOW;
          end
        end
        PH_DISC_LOW, PH_FRAME_LOW: begin
          r.clock_pin = 1'b0;
          if (timer_done({8'd0, half_len})) begin
            shift_reg = {shift_reg[14:0], ~d};
            bit_cnt = bit_cnt + 5'd1;
            if (disc) phase = PH_DISC_HIGH;
            else phase = PH_FRAME_HIGH;
          end
        end
        default: begin
          if (timer_done({8'd0, half_len})) begin
            if (bit_cnt >= total) begin
              if (disc) begin
                mapping = pick_mapping(shift_reg[7:0]);
              end else begin
                buttons = map_buttons();
                r.frame_done = 1'b1;
              end
              phase = PH_IDLE;
            end else if (disc) begin
              phase = PH_DISC_LOW;
            end else begin
              phase = PH_FRAME_LOW;
            end
          end
        end
      endcase
      r.button_bits    = buttons;
      r.active_mapping = mapping;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, logic [11:0] exp_v, logic [11:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(gpsr_result_t got);
      gpsr_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result transfer with no tick pending");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      cmp("latch_pin", 12'(exp_r.latch_pin), 12'(got.latch_pin));
      cmp("clock_pin", 12'(exp_r.clock_pin), 12'(got.clock_pin));
      cmp("button_bits", exp_r.button_bits, got.button_bits);
      cmp("frame_done", 12'(exp_r.frame_done), 12'(got.frame_done));
      cmp("active_mapping", 12'(exp_r.active_mapping), 12'(got.active_mapping));
      cmp("busy_res", 12'(exp_r.busy_res), 12'(got.busy_res));
    endfunction
  endclass

  pad_scoreboard sb;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          burst_left = 0;
  int          quiet = 0;
  int          ticks_sent = 0;
  bit          src_gaps = 1'b1;
  bit          rcv_stalls = 1'b1;
  logic [15:0] cur_pat = 16'h0000;

  game_pad_serial_reader_top u_top (.*);

  always #2 clk = ~clk;

  // Result side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD - 1;
      hold_seen <= hold_asks;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end else if (rcv_stalls && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      burst_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Transfers are observed mid-cycle, where every handshake signal is settled.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(data_pin, scan_request);
      if (out_valid && out_ready) begin
        sb.check_result({latch_pin, clock_pin, button_bits, frame_done,
                         active_mapping, busy_res});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Offers one tick and waits for its transfer, then maybe leaves a gap.
  task automatic send_tick(input logic d, input logic req);
    in_valid <= 1'b1;
    data_pin <= d;
    scan_request <= req;
    do @(posedge clk); while (!in_ready);
    if (src_gaps && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // The data line carries the wanted bit on sampling ticks and noise elsewhere.
  task automatic push_tick(input logic req);
    logic d;
    if (sb.samples_next()) d = ~cur_pat[4'd15 - sb.bit_cnt[3:0]];
    else d = 1'($urandom_range(0, 1));
    send_tick(d, req);
    ticks_sent++;
  endtask

  task automatic run_until_idle(input int req_pct);
    while (sb.phase != PH_IDLE) push_tick($urandom_range(0, 99) < req_pct);
  endtask

  // Idle ticks, a scan request, then the frame with stray requests mixed in.
  task automatic play_frame(input logic [15:0] pat, input int lead, input int req_pct);
    cur_pat = pat;
    repeat (lead) push_tick(1'b0);
    push_tick(1'b1);
    run_until_idle(req_pct);
  endtask

  // Stops sending until every result is out and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no extra step.
  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Upper bytes of the 8 bit registers carry junk that must be dropped.
  task automatic configure(input logic [15:0] wait_v, input logic [7:0] latch_v,
                           input logic [7:0] half_v);
    put_reg(CFG_UNUSED, 16'($urandom));
    put_reg(CFG_STARTUP_WAIT, wait_v);
    put_reg(CFG_LATCH_TICKS, {8'($urandom), latch_v});
    put_reg(CFG_HALF_PERIOD, {8'($urandom), half_v});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pattern();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000 >> $urandom_range(0, 15);
      3: return ~(16'h8000 >> $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short durations, now and then zero or the longest allowed here.
  function automatic logic [7:0] pick_len(input int max_short, input int max_long);
    case ($urandom_range(0, 19))
      0: return 8'd0;
      1: return 8'(max_long);
      2, 3: return 8'($urandom_range(max_short, max_long));
      default: return 8'($urandom_range(1, max_short));
    endcase
  endfunction

  initial begin
    logic [7:0]  disc_byte;
    logic [15:0] wait_v;
    logic [7:0]  latch_v;
    logic [7:0]  half_v;
    int          phase_no;
    int          rand_start;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Start-up wait length only matters now, while the block still waits.
    case ($urandom_range(0, 2))
      0: wait_v = 16'd0;
      1: wait_v = 16'd1;
      default: wait_v = 16'($urandom_range(2, 100));
    endcase
    configure(wait_v, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));

    // The discovery frame picks the mapping used for the rest of the run.
    case ($urandom_range(0, 5))
      0: disc_byte = PAT_ONLY_B;
      1: disc_byte = PAT_ONLY_Y;
      2: disc_byte = PAT_ONLY_SELECT;
      3: disc_byte = PAT_ONLY_START;
      4: disc_byte = 8'h00;
      default: disc_byte = 8'($urandom);
    endcase
    cur_pat = {disc_byte, 8'($urandom)};
    run_until_idle(50);

    // Zero durations: no button, all, every button bit alone, then only the spare bits.
    settle();
    configure(16'hFFFF, 8'd0, 8'd0);
    play_frame(16'h0000, 1, 0);
    play_frame(16'hFFFF, 0, 50);
    for (int k = 0; k < 12; k++) play_frame(16'h8000 >> k, 0, 0);
    play_frame(16'h000F, 2, 100);

    // Longest latch pulse.
    settle();
    configure(16'd0, 8'd255, 8'd1);
    play_frame(rand_pattern(), 1, 5);

    // Random phases with a new setting each.
    phase_no = 0;
    rand_start = ticks_sent;
    while (ticks_sent - rand_start < RAND_TICKS) begin
      settle();
      latch_v = pick_len(3, 40);
      half_v = pick_len(2, 6);
      configure(16'($urandom), latch_v, half_v);
      if (phase_no == 0) hold_asks <= hold_asks + 1;
      repeat ($urandom_range(2, 6)) begin
        play_frame(rand_pattern(), $urandom_range(0, 3), $urandom_range(0, 30));
      end
      phase_no++;
    end

    // Last stretch with no idling on either side.
    settle();
    src_gaps = 1'b0;
    rcv_stalls <= 1'b0;
    configure(16'($urandom), pick_len(3, 40), pick_len(2, 6));
    repeat (3) begin
      play_frame(rand_pattern(), $urandom_range(0, 3), $urandom_range(0, 30));
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
